// ===== hdl/cmph_pkg.sv =====
package cmph_pkg;

	localparam int SAMPLE_W = 16;
	localparam int HEAD_W   = 16;
	localparam int IN_SCALE = 16;
	localparam int ANG_FRAC = 24;
	localparam int ATAN_LEN = 24;
	localparam int VEC_W    = 36;
	localparam int ANG_W    = 34;
	localparam int IDX_W    = 5;

	localparam logic signed [ANG_W-1:0] DEG90_Q = ANG_W'(90) << ANG_FRAC;

	typedef struct packed {
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ANG_W-1:0] z;
		logic                    ypos;
		logic                    yzero;
		logic                    xneg;
	} cmph_vec_t;

	function automatic logic signed [ANG_W-1:0] atan_q24(input logic [IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			5'd0:    r = ANG_W'(754974720);
			5'd1:    r = ANG_W'(445687602);
			5'd2:    r = ANG_W'(235489088);
			5'd3:    r = ANG_W'(119537938);
			5'd4:    r = ANG_W'(60000934);
			5'd5:    r = ANG_W'(30029717);
			5'd6:    r = ANG_W'(15018523);
			5'd7:    r = ANG_W'(7509720);
			5'd8:    r = ANG_W'(3754917);
			5'd9:    r = ANG_W'(1877466);
			5'd10:   r = ANG_W'(938734);
			5'd11:   r = ANG_W'(469367);
			5'd12:   r = ANG_W'(234684);
			5'd13:   r = ANG_W'(117342);
			5'd14:   r = ANG_W'(58671);
			5'd15:   r = ANG_W'(29335);
			5'd16:   r = ANG_W'(14668);
			5'd17:   r = ANG_W'(7334);
			5'd18:   r = ANG_W'(3667);
			5'd19:   r = ANG_W'(1833);
			5'd20:   r = ANG_W'(917);
			5'd21:   r = ANG_W'(458);
			5'd22:   r = ANG_W'(229);
			5'd23:   r = ANG_W'(115);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/cmph_prep.sv =====
module cmph_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                d_vld,
	input  logic signed [cmph_pkg::SAMPLE_W-1:0] x,
	input  logic signed [cmph_pkg::SAMPLE_W-1:0] y,
	output logic                                q_vld,
	output cmph_pkg::cmph_vec_t                 q
);
	import cmph_pkg::*;

	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;
	cmph_vec_t               nxt;
	cmph_vec_t               vec_s1;
	logic                    vld_s1;

	always_comb begin
		xs = VEC_W'(x) <<< IN_SCALE;
		ys = VEC_W'(y) <<< IN_SCALE;
		nxt.ypos  = (y > 0);
		nxt.yzero = (y == '0);
		nxt.xneg  = x[SAMPLE_W-1];
		nxt.a     = y[SAMPLE_W-1] ? -ys : ys;
		nxt.b     = y[SAMPLE_W-1] ? -xs : xs;
		nxt.z     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= nxt;
		end
	end

	assign q_vld = vld_s1;
	assign q     = vec_s1;

endmodule

// ===== hdl/cmph_cordic_stage.sv =====
module cmph_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                d_vld,
	input  cmph_pkg::cmph_vec_t d,
	output logic                q_vld,
	output cmph_pkg::cmph_vec_t q
);
	import cmph_pkg::*;

	logic signed [VEC_W-1:0] da;
	logic signed [VEC_W-1:0] db;
	logic signed [ANG_W-1:0] ang;
	cmph_vec_t               nxt;
	cmph_vec_t               vec_s1;
	logic                    vld_s1;

	always_comb begin
		da  = d.b >>> STEP;
		db  = d.a >>> STEP;
		ang = atan_q24(IDX_W'(STEP));
		nxt = d;
		if (!d.b[VEC_W-1]) begin
			nxt.a = d.a + da;
			nxt.b = d.b - db;
			nxt.z = d.z + ang;
		end else begin
			nxt.a = d.a - da;
			nxt.b = d.b + db;
			nxt.z = d.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= nxt;
		end
	end

	assign q_vld = vld_s1;
	assign q     = vec_s1;

endmodule

// ===== hdl/cmph_final.sv =====
module cmph_final #(
	parameter int FRAC_BITS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              d_vld,
	input  cmph_pkg::cmph_vec_t               d,
	output logic                              q_vld,
	output logic signed [cmph_pkg::HEAD_W-1:0] q_heading
);
	import cmph_pkg::*;

	localparam int SH     = ANG_FRAC - FRAC_BITS;
	localparam int HI_RAW = 180 * (1 << FRAC_BITS);
	localparam int LO_RAW = -90 * (1 << FRAC_BITS);
	localparam int HI_INT = (HI_RAW > 32767) ? 32767 : HI_RAW;
	localparam int LO_INT = (LO_RAW < -32768) ? -32768 : LO_RAW;
	localparam logic signed [ANG_W-1:0]  RND   = ANG_W'(1) << (SH - 1);
	localparam logic signed [ANG_W-1:0]  HI_W  = ANG_W'(HI_INT);
	localparam logic signed [ANG_W-1:0]  LO_W  = ANG_W'(LO_INT);
	localparam logic signed [HEAD_W-1:0] HI_H  = HEAD_W'(HI_INT);
	localparam logic signed [HEAD_W-1:0] LO_H  = HEAD_W'(LO_INT);

	logic signed [ANG_W-1:0]  hq;
	logic signed [ANG_W-1:0]  hr;
	logic signed [ANG_W-1:0]  h_s1;
	logic                     yzero_s1;
	logic                     xneg_s1;
	logic                     vld_s1;
	logic signed [HEAD_W-1:0] hc;
	logic signed [HEAD_W-1:0] head_s2;
	logic                     vld_s2;

	always_comb begin
		hq = d.ypos ? (DEG90_Q - d.z) : -d.z;
		hr = (hq + RND) >>> SH;
	end

	always_comb begin
		if (yzero_s1) begin
			hc = xneg_s1 ? HI_H : '0;
		end else if (h_s1 > HI_W) begin
			hc = HI_H;
		end else if (h_s1 < LO_W) begin
			hc = LO_H;
		end else begin
			hc = h_s1[HEAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1     <= hr;
			yzero_s1 <= d.yzero;
			xneg_s1  <= d.xneg;
			head_s2  <= hc;
		end
	end

	assign q_vld     = vld_s2;
	assign q_heading = head_s2;

endmodule

// ===== hdl/cmph_skid.sv =====
module cmph_skid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         d_vld,
	output logic                         d_rdy,
	input  logic [cmph_pkg::HEAD_W-1:0]  d,
	output logic                         q_vld,
	input  logic                         q_rdy,
	output logic [cmph_pkg::HEAD_W-1:0]  q
);
	import cmph_pkg::*;

	logic [HEAD_W-1:0] out_q;
	logic [HEAD_W-1:0] skid_q;
	logic              out_v_q;
	logic              skid_v_q;

	assign d_rdy = !skid_v_q;
	assign q_vld = out_v_q;
	assign q     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (q_rdy || !out_v_q) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= d_vld;
			end
		end else if (d_vld && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rdy || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : d;
		end else if (d_vld && !skid_v_q) begin
			skid_q <= d;
		end
	end

endmodule

// ===== hdl/compass_heading_from_mag_xy.sv =====
// Path: prep register, CORDIC stages, final round and clamp registers, skid output.
// Throughput: one request per cycle while s_tready is high; one stage per CORDIC step.
// Output stall: a two-entry output buffer keeps s_tready high while one result waits.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module compass_heading_from_mag_xy #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] x_field, [31:16] y_field
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [15:0] heading_deg
);
	import cmph_pkg::*;

	localparam int NS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	cmph_vec_t                pipe_d [0:NS];
	logic [NS:0]              pipe_v;
	logic                     en;
	logic                     fin_vld;
	logic signed [HEAD_W-1:0] fin_head;

	assign s_tready = en;

	cmph_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d_vld  (s_tvalid),
		.x      (s_tdata[15:0]),
		.y      (s_tdata[31:16]),
		.q_vld  (pipe_v[0]),
		.q      (pipe_d[0])
	);

	for (genvar i = 0; i < NS; i++) begin : g_step
		cmph_cordic_stage #(
			.STEP (i)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_vld  (pipe_v[i]),
			.d      (pipe_d[i]),
			.q_vld  (pipe_v[i+1]),
			.q      (pipe_d[i+1])
		);
	end

	cmph_final #(
		.FRAC_BITS (FRAC_BITS)
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.d_vld     (pipe_v[NS]),
		.d         (pipe_d[NS]),
		.q_vld     (fin_vld),
		.q_heading (fin_head)
	);

	cmph_skid u_skid (
		.clk    (clk),
		.arst_n (arst_n),
		.d_vld  (fin_vld),
		.d_rdy  (en),
		.d      (fin_head),
		.q_vld  (m_tvalid),
		.q_rdy  (m_tready),
		.q      (m_tdata)
	);

endmodule

// ===== sim/tb_compass_heading_from_mag_xy.sv =====
module tb_compass_heading_from_mag_xy;

	localparam int     STEPS       = 16;
	localparam int     FRAC        = 7;
	localparam int     ANG_Q       = 24;
	localparam int     N_RANDOM    = 800;
	localparam int     TAIL_CYCLES = STEPS + 12;
	localparam int     N_DIRECTED  = 22;
	localparam longint HEAD_LO     = -(longint'(90) << FRAC);
	localparam longint HEAD_HI     = longint'(180) << FRAC;

	typedef struct packed {
		logic [cmph_pkg::SAMPLE_W-1:0] x;
		logic [cmph_pkg::SAMPLE_W-1:0] y;
		logic                          known;
		logic [cmph_pkg::HEAD_W-1:0]   heading;
	} heading_case_t;

	typedef struct packed {
		logic [cmph_pkg::SAMPLE_W-1:0] x;
		logic [cmph_pkg::SAMPLE_W-1:0] y;
		logic [cmph_pkg::HEAD_W-1:0]   heading;
	} heading_want_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	heading_want_t heading_q[$];
	int            fail_cnt = 0;
	int            n_sent   = 0;

	// atan(2^-i) in degrees, 24 fractional bits
	longint atan_deg_tab [24] = '{
		754974720, 445687602, 235489088, 119537938,
		60000934, 30029717, 15018523, 7509720,
		3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335,
		14668, 7334, 3667, 1833,
		917, 458, 229, 115
	};

	heading_case_t dir_cases [N_DIRECTED] = '{
		'{16'sd0,      16'sd0,      1'b1, 16'sd0},
		'{16'sd1,      16'sd0,      1'b1, 16'sd0},
		'{16'sd32767,  16'sd0,      1'b1, 16'sd0},
		'{-16'sd1,     16'sd0,      1'b1, 16'sd23040},
		'{-16'sd32768, 16'sd0,      1'b1, 16'sd23040},
		'{16'sd0,      16'sd1,      1'b0, 16'sd0},
		'{16'sd0,      -16'sd1,     1'b0, 16'sd0},
		'{16'sd0,      16'sd32767,  1'b0, 16'sd0},
		'{16'sd0,      -16'sd32768, 1'b0, 16'sd0},
		'{16'sd1,      16'sd1,      1'b0, 16'sd0},
		'{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
		'{16'sd1,      -16'sd1,     1'b0, 16'sd0},
		'{-16'sd1,     16'sd1,      1'b0, 16'sd0},
		'{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
		'{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
		'{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
		'{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
		'{16'sd32767,  16'sd1,      1'b0, 16'sd0},
		'{-16'sd32768, 16'sd1,      1'b0, 16'sd0},
		'{16'sd32767,  -16'sd1,     1'b0, 16'sd0},
		'{-16'sd32768, -16'sd1,     1'b0, 16'sd0},
		'{16'sd100,    -16'sd32768, 1'b0, 16'sd0}
	};

	compass_heading_from_mag_xy u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [15:0] predict_heading(input logic signed [15:0] x,
			input logic signed [15:0] y);
		longint a, b, z, da, db, hq, h;
		int     i;
		if (y == 0) begin
			h = (x < 0) ? HEAD_HI : 0;
		end else begin
			a = (y > 0) ? longint'(y) : -longint'(y);
			b = (y > 0) ? longint'(x) : -longint'(x);
			a = a <<< 16;
			b = b <<< 16;
			z = 0;
			for (i = 0; i < STEPS && i < 24; i++) begin
				da = b >>> i;
				db = a >>> i;
				if (b >= 0) begin
					a = a + da;
					b = b - db;
					z = z + atan_deg_tab[i];
				end else begin
					a = a - da;
					b = b + db;
					z = z - atan_deg_tab[i];
				end
			end
			hq = (y > 0) ? (longint'(90) <<< ANG_Q) - z : -z;
			h = (hq + (longint'(1) <<< (ANG_Q - FRAC - 1))) >>> (ANG_Q - FRAC);
			if (h < HEAD_LO)
				h = HEAD_LO;
			if (h > HEAD_HI)
				h = HEAD_HI;
		end
		if (h > 32767)
			h = 32767;
		if (h < -32768)
			h = -32768;
		return h[15:0];
	endfunction

	function automatic logic [15:0] rand_sample();
		logic [15:0] edges [5];
		edges = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};
		case ($urandom_range(0, 9))
			0: return edges[$urandom_range(0, 4)];
			1: return 16'($urandom_range(0, 16)) - 16'd8;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_xy(input logic [15:0] x, input logic [15:0] y, input logic known,
			input logic [15:0] heading);
		int            gap;
		heading_want_t want;
		gap = (((n_sent / 40) % 3) == 1) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		do @(posedge clk); while (!s_tready);
		want.x       = x;
		want.y       = y;
		want.heading = known ? heading : predict_heading(x, y);
		heading_q.push_back(want);
		n_sent++;
	endtask

	initial begin
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (k = 0; k < N_DIRECTED; k++)
			send_xy(dir_cases[k].x, dir_cases[k].y, dir_cases[k].known, dir_cases[k].heading);
		for (k = 0; k < N_RANDOM; k++)
			send_xy(rand_sample(), rand_sample(), 1'b0, '0);
		s_tvalid <= 1'b0;
		while (heading_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("compass_heading_from_mag_xy regression: pass");
		else
			$display("compass_heading_from_mag_xy regression: fail");
		$finish;
	end

	initial begin
		heading_want_t want;
		int            gap;
		int            n_recv;
		n_recv = 0;
		wait (arst_n);
		forever begin
			gap = (((n_recv / 57) % 3) == 2) ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			n_recv++;
			if (heading_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unrequested heading, expected none, actual %0d", $time,
					$signed(m_tdata));
			end else begin
				want = heading_q.pop_front();
				if (m_tdata !== want.heading) begin
					fail_cnt++;
					$display("%0t: heading x=%0d y=%0d expected %0d actual %0d", $time,
						$signed(want.x), $signed(want.y), $signed(want.heading),
						$signed(m_tdata));
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("compass_heading_from_mag_xy regression: fail");
		$finish;
	end

endmodule
